// ===== design/cfle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content-length frame extractor package
// Shared types, codes and constants for the frame extractor and its parser.
// ----------------------------------------------------------------------------
package cfle_pkg;

  // Default width of the message length and body counters.
  localparam int LENGTH_BITS_DEFAULT = 32;

  // Header byte limit register.
  localparam int          LIMIT_W     = 17;
  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  // Register map (index taken from the word address).
  localparam int         ADDR_W           = 3;
  localparam logic       REG_HEADER_LIMIT = 1'b0;

  // Length of the "content-length:" key.
  localparam logic [3:0] KEY_LEN = 4'd15;

  // Character codes.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_BODY    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_GARBAGE = 2'd3
  } cfle_kind_t;

  // Top-level phase of the parser.
  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } cfle_phase_t;

  // How the bytes of the current header line are treated.
  typedef enum logic [1:0] {
    MODE_MATCH  = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_DIGITS = 2'd2,
    MODE_IGNORE = 2'd3
  } cfle_mode_t;

  // One result item.
  typedef struct packed {
    cfle_kind_t  kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
  } cfle_result_t;

  // Lowercase text of the length key, one character per index.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== design/content_length_frame_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content-length frame extractor
// Splits a byte stream into messages framed by a Content-Length header.
// ----------------------------------------------------------------------------
// Usage: bytes enter on in_byte with in_valid/in_ready, one item per byte.
// Results leave on out_kind/out_byte/out_first/out_last with out_valid and
// out_ready: body bytes of each message (first and last marked), and single
// event items for an empty frame, a header with no length, or a header that
// ran past header_limit bytes. Header bytes that cause no event give no item.
// Each byte is held in an input register, processed by the parser, and its
// result is held in an output register. One byte is taken every cycle while
// the output side keeps taking results. When out_ready is low the output
// register holds its item, the input register can still take one more byte,
// and after that in_ready drops until the output moves again.
// Reset clears the parser to the start of a header, empties both registers
// and sets header_limit to 65536. header_limit is written over the APB port
// at address 0; the user must write it only while no item is in flight, as
// the block does not enforce this. pready is always high.
// ----------------------------------------------------------------------------
module content_length_frame_extractor import cfle_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Byte input.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  // Result output.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_byte,
  output logic                   out_first,
  output logic                   out_last
);

  logic [LIMIT_W-1:0] header_limit;
  logic               reg_index;

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               out_slot_free;
  logic               step_go;

  logic               res_valid;
  cfle_result_t       res;
  cfle_result_t       out_item;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (reg_index == REG_HEADER_LIMIT)) begin
      header_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'h0;
    if (reg_index == REG_HEADER_LIMIT) begin
      prdata = {{(32-LIMIT_W){1'b0}}, header_limit};
    end
  end

  // Handshake between the input register, parser and output register.
  assign out_slot_free = !out_valid || out_ready;
  assign step_go       = s1_valid && out_slot_free;
  assign in_ready      = !s1_valid || step_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
    end
  end

  // Parser.
  cfle_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_go),
    .step_byte    (s1_byte),
    .header_limit (header_limit),
    .result_valid (res_valid),
    .result       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_slot_free) begin
      out_valid <= step_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && res_valid) begin
      out_item <= res;
    end
  end

  assign out_kind  = out_item.kind;
  assign out_byte  = out_item.data;
  assign out_first = out_item.first;
  assign out_last  = out_item.last;

  // Event items always close a frame.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != KIND_BODY) |-> out_last)
    else $error("event item without last mark");

  // Event items carry no byte and no first mark.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != KIND_BODY) |-> (out_byte == 8'h00) && !out_first)
    else $error("event item with body payload");

  // A byte waiting behind a stalled output stays in the input register.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_slot_free |=> s1_valid && (s1_byte == $past(s1_byte)))
    else $error("input register lost a pending byte");

endmodule
`default_nettype wire

// ===== design/cfle_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Content-length frame parser
// Holds the header and body state and processes one byte per step.
// ----------------------------------------------------------------------------
module cfle_parser import cfle_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step_en,
  input  wire logic [7:0]         step_byte,
  input  wire logic [LIMIT_W-1:0] header_limit,
  output logic                    result_valid,
  output cfle_result_t            result
);

  // Parser state.
  cfle_phase_t             phase, phase_next;
  logic [1:0]              term_progress, term_progress_next;
  cfle_mode_t              line_mode, line_mode_next;
  logic [3:0]              match_index, match_index_next;
  logic [LENGTH_BITS-1:0]  length_value, length_value_next;
  logic                    length_seen, length_seen_next;
  logic [LIMIT_W-1:0]      header_count, header_count_next;
  logic [LENGTH_BITS-1:0]  body_remaining, body_remaining_next;

  // Byte classification.
  logic                    is_cr, is_lf, is_blank, is_digit;
  logic [3:0]              digit_val;
  logic [7:0]              lower_byte;
  logic                    terminator, over_limit;
  logic [LENGTH_BITS-1:0]  body_left;
  logic                    body_last;

  // Saturating decimal accumulate: value * 10 + digit, with four guard bits.
  logic [LENGTH_BITS+3:0]  scaled;
  logic                    scaled_ovf;
  logic [LENGTH_BITS-1:0]  length_acc;

  assign is_cr      = (step_byte == CH_CR);
  assign is_lf      = (step_byte == CH_LF);
  assign is_blank   = (step_byte == CH_SP) || (step_byte == CH_TAB);
  assign is_digit   = (step_byte >= CH_ZERO) && (step_byte <= CH_NINE);
  assign digit_val  = 4'(step_byte - CH_ZERO);
  assign lower_byte = (step_byte inside {["A":"Z"]}) ? 8'(step_byte + 8'd32) : step_byte;
  assign terminator = is_lf && (term_progress == 2'd3);
  assign over_limit = (header_count >= header_limit);
  assign body_left  = (body_remaining != '0) ? body_remaining - 1'b1 : '0;
  assign body_last  = (body_left == '0);

  assign scaled     = ({4'b0000, length_value} << 3) + ({4'b0000, length_value} << 1)
                      + {{LENGTH_BITS{1'b0}}, digit_val};
  assign scaled_ovf = |scaled[LENGTH_BITS+3:LENGTH_BITS];
  assign length_acc = scaled_ovf ? '1 : scaled[LENGTH_BITS-1:0];

  // Next state for one byte.
  always_comb begin
    phase_next          = phase;
    term_progress_next  = term_progress;
    line_mode_next      = line_mode;
    match_index_next    = match_index;
    length_value_next   = length_value;
    length_seen_next    = length_seen;
    header_count_next   = header_count;
    body_remaining_next = body_remaining;

    if (phase == PH_BODY) begin
      body_remaining_next = body_left;
      if (body_last) begin
        phase_next         = PH_HEADER;
        term_progress_next = 2'd0;
        line_mode_next     = MODE_MATCH;
        match_index_next   = 4'd0;
        length_value_next  = '0;
        length_seen_next   = 1'b0;
        header_count_next  = '0;
      end
    end else if (terminator) begin
      // End of header block: restart the header state, enter the body if any.
      term_progress_next = 2'd0;
      line_mode_next     = MODE_MATCH;
      match_index_next   = 4'd0;
      length_value_next  = '0;
      length_seen_next   = 1'b0;
      header_count_next  = '0;
      if (length_seen && (length_value != '0)) begin
        phase_next          = PH_BODY;
        length_value_next   = length_value;
        length_seen_next    = 1'b1;
        body_remaining_next = length_value;
      end
    end else begin
      // Line processing.
      if (is_lf && ((term_progress == 2'd1) || (term_progress == 2'd3))) begin
        line_mode_next   = MODE_MATCH;
        match_index_next = 4'd0;
      end else begin
        case (line_mode)
          MODE_MATCH: begin
            if ((match_index < KEY_LEN) && (lower_byte == key_char(match_index))) begin
              match_index_next = match_index + 1'b1;
              if (match_index_next >= KEY_LEN) begin
                length_value_next = '0;
                length_seen_next  = 1'b0;
                line_mode_next    = MODE_SKIP;
              end
            end else begin
              line_mode_next = MODE_IGNORE;
            end
          end
          MODE_SKIP: begin
            if (is_blank) begin
              line_mode_next = MODE_SKIP;
            end else if (is_digit) begin
              length_seen_next  = 1'b1;
              length_value_next = {{(LENGTH_BITS-4){1'b0}}, digit_val};
              line_mode_next    = MODE_DIGITS;
            end else begin
              line_mode_next = MODE_IGNORE;
            end
          end
          MODE_DIGITS: begin
            if (is_digit) begin
              length_value_next = length_acc;
            end else begin
              line_mode_next = MODE_IGNORE;
            end
          end
          default: begin
            line_mode_next = MODE_IGNORE;
          end
        endcase
      end

      // Progress toward CR LF CR LF.
      if (is_cr) begin
        term_progress_next = (term_progress == 2'd2) ? 2'd3 : 2'd1;
      end else if (is_lf) begin
        term_progress_next = (term_progress == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        term_progress_next = 2'd0;
      end

      // Header too long: throw away everything seen so far.
      if (over_limit) begin
        term_progress_next = 2'd0;
        line_mode_next     = MODE_MATCH;
        match_index_next   = 4'd0;
        length_value_next  = '0;
        length_seen_next   = 1'b0;
        header_count_next  = '0;
      end else begin
        header_count_next = LIMIT_W'(header_count + 1'b1);
      end
    end
  end

  // Result item for one byte.
  always_comb begin
    result_valid = 1'b0;
    result.kind  = KIND_BODY;
    result.data  = 8'h00;
    result.first = 1'b0;
    result.last  = 1'b1;
    if (phase == PH_BODY) begin
      result_valid = 1'b1;
      result.data  = step_byte;
      result.first = (body_remaining == length_value);
      result.last  = body_last;
    end else if (terminator) begin
      if (!length_seen) begin
        result_valid = 1'b1;
        result.kind  = KIND_DROPPED;
      end else if (length_value == '0) begin
        result_valid = 1'b1;
        result.kind  = KIND_EMPTY;
      end
    end else if (over_limit) begin
      result_valid = 1'b1;
      result.kind  = KIND_GARBAGE;
    end
  end

  // State registers, advanced once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      term_progress  <= 2'd0;
      line_mode      <= MODE_MATCH;
      match_index    <= 4'd0;
      length_value   <= '0;
      length_seen    <= 1'b0;
      header_count   <= '0;
      body_remaining <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      term_progress  <= term_progress_next;
      line_mode      <= line_mode_next;
      match_index    <= match_index_next;
      length_value   <= length_value_next;
      length_seen    <= length_seen_next;
      header_count   <= header_count_next;
      body_remaining <= body_remaining_next;
    end
  end

endmodule
`default_nettype wire
